/* hw/rtl/pkm_pkg.sv */
package pkm_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KEY_W = 64;
	localparam int VAL_W = 64;
	localparam int ENTRY_W = 11;

	// Only the product bits that reach the slot index after the final xor-shift are kept.
	localparam int PROD_W = IDX_W + 13;
	localparam logic [31:0] HASH_MUL = 32'h85eb_ca6b;

	// An insert is refused once four times the count reaches three times the capacity.
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(3 * CAPACITY / 4);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_UPSERT = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_ZERO_KEY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_ADDR,
		S_PROBE,
		S_VALUE,
		S_RESP
	} state_t;

endpackage

/* hw/rtl/pointer_keyed_hash_map.sv */
// A lookup or upsert passes through S_ADDR, then S_PROBE for each slot probed, then S_RESP on a
// miss; a hit goes through S_VALUE before S_RESP. One slot is probed per cycle through the key
// memory's read port. A new beat can be taken in the cycle after the result is loaded.
// A zero key or an unused op goes straight to S_RESP; a clear sweeps every slot and then
// answers. After reset a clearing pass over every slot runs before the first input beat is
// taken.
module pointer_keyed_hash_map (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // key [63:0], value [127:64]
	input  logic [1:0]   s_tuser,   // op [1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,   // found [0], old_value [64:1], entry_count [75:65], zero pad
	output logic [1:0]   m_tuser    // status [1:0]
);

	localparam int IW = pkm_pkg::IDX_W;
	localparam int CW = pkm_pkg::CNT_W;

	pkm_pkg::state_t                 state_q, state_d;
	pkm_pkg::op_t                    op_q, s_op;
	logic [pkm_pkg::KEY_W-1:0]       key_q, s_key;
	logic [pkm_pkg::VAL_W-1:0]       value_q;
	logic [IW-1:0]                   idx_q, hash_idx, sweep_q;
	logic [CW-1:0]                   cnt_q;
	logic                            clr_resp_q;
	logic                            res_found_q;
	logic [pkm_pkg::VAL_W-1:0]       res_old_q;
	pkm_pkg::status_t                res_status_q;

	logic                            accept, out_free, at_limit;
	logic                            key_hit, key_empty, do_insert, do_update, sweep_end;
	logic                            key_we, val_we;
	logic [IW-1:0]                   key_waddr, key_raddr;
	logic [pkm_pkg::KEY_W-1:0]       key_wdata, key_rdata;
	logic [pkm_pkg::VAL_W-1:0]       val_rdata;

	assign s_op  = pkm_pkg::op_t'(s_tuser);
	assign s_key = s_tdata[63:0];

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign at_limit  = cnt_q >= pkm_pkg::FULL_COUNT;
	assign key_hit   = key_rdata == key_q;
	assign key_empty = key_rdata == '0;
	assign sweep_end = (state_q == pkm_pkg::S_SWEEP) && (sweep_q == pkm_pkg::LAST_SLOT);

	pkm_hash u_hash (
		.clk  (clk),
		.load (accept),
		.key  (s_key),
		.idx  (hash_idx)
	);

	pkm_ram #(.WIDTH(pkm_pkg::KEY_W), .DEPTH(pkm_pkg::CAPACITY)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	pkm_ram #(.WIDTH(pkm_pkg::VAL_W), .DEPTH(pkm_pkg::CAPACITY)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (idx_q),
		.wdata (value_q),
		.raddr (idx_q),
		.rdata (val_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pkm_pkg::S_SWEEP: begin
				if (sweep_end) begin
					state_d = clr_resp_q ? pkm_pkg::S_RESP : pkm_pkg::S_IDLE;
				end
			end
			pkm_pkg::S_IDLE: begin
				if (accept) begin
					case (s_op)
						pkm_pkg::OP_CLEAR: state_d = pkm_pkg::S_SWEEP;
						pkm_pkg::OP_LOOKUP, pkm_pkg::OP_UPSERT: begin
							state_d = (s_key == '0) ? pkm_pkg::S_RESP : pkm_pkg::S_ADDR;
						end
						default: state_d = pkm_pkg::S_RESP;
					endcase
				end
			end
			pkm_pkg::S_ADDR: state_d = pkm_pkg::S_PROBE;
			pkm_pkg::S_PROBE: begin
				if (key_hit) begin
					state_d = pkm_pkg::S_VALUE;
				end else if (key_empty) begin
					state_d = pkm_pkg::S_RESP;
				end
			end
			pkm_pkg::S_VALUE: state_d = pkm_pkg::S_RESP;
			pkm_pkg::S_RESP: begin
				if (out_free) begin
					state_d = pkm_pkg::S_IDLE;
				end
			end
			default: state_d = pkm_pkg::S_SWEEP;
		endcase
	end

	always_comb begin
		s_tready  = state_q == pkm_pkg::S_IDLE;
		do_insert = (state_q == pkm_pkg::S_PROBE) && !key_hit && key_empty
			&& (op_q == pkm_pkg::OP_UPSERT) && !at_limit;
		do_update = (state_q == pkm_pkg::S_VALUE) && (op_q == pkm_pkg::OP_UPSERT);
		val_we    = do_insert || do_update;
		key_we    = (state_q == pkm_pkg::S_SWEEP) || do_insert;
		key_waddr = (state_q == pkm_pkg::S_SWEEP) ? sweep_q : idx_q;
		key_wdata = (state_q == pkm_pkg::S_SWEEP) ? '0 : key_q;
		// The next slot is fetched while the current one is compared.
		key_raddr = (state_q == pkm_pkg::S_ADDR) ? hash_idx : idx_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pkm_pkg::S_SWEEP;
			sweep_q    <= '0;
			clr_resp_q <= 1'b0;
			cnt_q      <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pkm_pkg::S_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (sweep_end) begin
				cnt_q <= '0;
			end else if (do_insert) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (accept && s_op == pkm_pkg::OP_CLEAR) begin
				sweep_q    <= '0;
				clr_resp_q <= 1'b1;
			end
			if (state_q == pkm_pkg::S_RESP && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= s_op;
			key_q        <= s_key;
			value_q      <= s_tdata[127:64];
			res_found_q  <= 1'b0;
			res_old_q    <= '0;
			res_status_q <= ((s_op inside {pkm_pkg::OP_LOOKUP, pkm_pkg::OP_UPSERT})
				&& s_key == '0) ? pkm_pkg::ST_ZERO_KEY : pkm_pkg::ST_OK;
		end
		if (state_q == pkm_pkg::S_ADDR) begin
			idx_q <= hash_idx;
		end else if (state_q == pkm_pkg::S_PROBE && !key_hit && !key_empty) begin
			idx_q <= idx_q + 1'b1;
		end
		if (state_q == pkm_pkg::S_PROBE && !key_hit && key_empty
			&& op_q == pkm_pkg::OP_UPSERT && at_limit) begin
			res_status_q <= pkm_pkg::ST_FULL;
		end
		if (state_q == pkm_pkg::S_VALUE) begin
			res_found_q <= 1'b1;
			res_old_q   <= val_rdata;
		end
		if (state_q == pkm_pkg::S_RESP && out_free) begin
			m_tdata <= {4'b0, pkm_pkg::ENTRY_W'(cnt_q), res_old_q, res_found_q};
			m_tuser <= res_status_q;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pkm_pkg::FULL_COUNT)
		else $error("occupied count passed the load limit");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> cnt_q == CW'($past(cnt_q) + 1'b1))
		else $error("insert did not advance the occupied count");

	a_sweep_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_end |=> cnt_q == '0)
		else $error("clearing pass left a nonzero count");

	a_resp_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pkm_pkg::S_RESP && out_free) |=> m_tvalid)
		else $error("result was not presented");

	a_no_write_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pkm_pkg::S_PROBE && at_limit) |-> !do_insert)
		else $error("key claimed a slot at the load limit");

endmodule

/* hw/rtl/pkm_ram.sv */
module pkm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/pkm_hash.sv */
module pkm_hash (
	input  logic                        clk,
	input  logic                        load,
	input  logic [pkm_pkg::KEY_W-1:0]   key,
	output logic [pkm_pkg::IDX_W-1:0]   idx
);

	localparam int PW = pkm_pkg::PROD_W;

	logic [PW-1:0]    mix;
	logic [PW+31:0]   prod_full;
	logic [PW-1:0]    prod_q;

	// Low product bits depend only on low operand bits, so a narrow multiply suffices.
	assign mix = key[PW-1:0] ^ key[PW+15:16];
	assign prod_full = {32'b0, mix} * {{PW{1'b0}}, pkm_pkg::HASH_MUL};

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= prod_full[PW-1:0];
		end
	end

	assign idx = prod_q[pkm_pkg::IDX_W-1:0] ^ prod_q[pkm_pkg::IDX_W+12:13];

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import pkm_pkg::*;

	localparam logic [63:0] MIX_MUL = 64'h85eb_ca6b;
	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct {
		op_t         op;
		logic [63:0] key;
		logic [63:0] value;
	} map_cmd_t;

	typedef struct {
		logic         found;
		logic [63:0]  old_value;
		status_t      status;
		logic [10:0]  entry_count;
	} map_reply_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;   // key [63:0], value [127:64]
	logic [1:0]   s_tuser = '0;   // op [1:0]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [79:0]  m_tdata;        // found [0], old_value [64:1], entry_count [75:65]
	logic [1:0]   m_tuser;        // status [1:0]

	pointer_keyed_hash_map u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the table contents.
	logic [63:0] shadow_keys [CAPACITY];
	logic [63:0] shadow_vals [CAPACITY];
	int          shadow_count;

	map_cmd_t    pending_cmds [$];
	map_reply_t  expected_replies [$];
	logic [63:0] key_pool [$];

	int send_idle_pct = 37;
	int recv_idle_pct = 85;
	int errors = 0;
	int cycles = 0;
	int replies_checked = 0;
	int n_lookup = 0, n_upsert = 0, n_clear = 0, n_nop = 0;
	int n_hit = 0, n_full = 0, n_zero = 0;

	bit         beat_taken = 1'b0;
	map_cmd_t   drive_cmd;
	map_reply_t want;

	function automatic logic [IDX_W-1:0] home_slot_of(input logic [63:0] key);
		logic [63:0] x;
		x = key ^ (key >> 16);
		x = x * MIX_MUL;
		x = x ^ (x >> 13);
		return x[IDX_W-1:0];
	endfunction

	function automatic void empty_shadow();
		for (int i = 0; i < CAPACITY; i++) begin
			shadow_keys[i] = '0;
			shadow_vals[i] = '0;
		end
		shadow_count = 0;
	endfunction

	function automatic map_reply_t predict_map_op(input op_t op, input logic [63:0] key,
			input logic [63:0] value);
		map_reply_t r;
		logic [IDX_W-1:0] idx;
		bit hit;
		bit slot_free;
		r = '{found: 1'b0, old_value: '0, status: ST_OK, entry_count: '0};
		hit = 1'b0;
		slot_free = 1'b0;
		case (op)
			OP_CLEAR: begin
				n_clear++;
				for (int i = 0; i < CAPACITY; i++)
					shadow_keys[i] = '0;
				shadow_count = 0;
			end
			OP_LOOKUP, OP_UPSERT: begin
				if (op == OP_LOOKUP)
					n_lookup++;
				else
					n_upsert++;
				if (key == '0) begin
					r.status = ST_ZERO_KEY;
					n_zero++;
				end else begin
					idx = home_slot_of(key);
					for (int n = 0; n < CAPACITY; n++) begin
						if (shadow_keys[idx] == '0) begin
							slot_free = 1'b1;
							break;
						end
						if (shadow_keys[idx] == key) begin
							hit = 1'b1;
							break;
						end
						idx = idx + 1'b1;
					end
					if (hit) begin
						n_hit++;
						r.found = 1'b1;
						r.old_value = shadow_vals[idx];
						if (op == OP_UPSERT)
							shadow_vals[idx] = value;
					end else if (op == OP_UPSERT) begin
						if (shadow_count * 4 >= CAPACITY * 3 || !slot_free) begin
							r.status = ST_FULL;
							n_full++;
						end else begin
							shadow_keys[idx] = key;
							shadow_vals[idx] = value;
							shadow_count++;
						end
					end
				end
			end
			default: n_nop++;
		endcase
		r.entry_count = 11'(shadow_count);
		return r;
	endfunction

	// Input side: the posedge records the accepted beat, the negedge presents the next one.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			expected_replies.push_back(predict_map_op(op_t'(s_tuser), s_tdata[63:0],
				s_tdata[127:64]));
			beat_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || beat_taken)) begin
			beat_taken = 1'b0;
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drive_cmd = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= drive_cmd.op;
				s_tdata <= {drive_cmd.value, drive_cmd.key};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output side.
	always @(negedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, got tdata %h tuser %0d",
					$time, m_tdata, m_tuser);
			end else begin
				want = expected_replies.pop_front();
				replies_checked++;
				if (m_tdata[0] !== want.found) begin
					errors++;
					$display("%0t: found mismatch, expected %0d, got %0d",
						$time, want.found, m_tdata[0]);
				end
				if (m_tdata[64:1] !== want.old_value) begin
					errors++;
					$display("%0t: old_value mismatch, expected %h, got %h",
						$time, want.old_value, m_tdata[64:1]);
				end
				if (m_tuser !== want.status) begin
					errors++;
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, want.status, m_tuser);
				end
				if (m_tdata[75:65] !== want.entry_count) begin
					errors++;
					$display("%0t: entry_count mismatch, expected %0d, got %0d",
						$time, want.entry_count, m_tdata[75:65]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still outstanding", $time,
				expected_replies.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic push_cmd(input op_t op, input logic [63:0] key, input logic [63:0] value);
		pending_cmds.push_back('{op: op, key: key, value: value});
	endtask

	function automatic logic [63:0] rand_word();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0)
			return '1;
		if (pick == 1)
			return '0;
		return {$urandom, $urandom};
	endfunction

	// Bits 39 and up never reach the home slot, so flipping them yields a colliding key.
	function automatic logic [63:0] fresh_key();
		int pick;
		logic [63:0] k;
		pick = $urandom_range(99);
		if (pick < 20 && key_pool.size() != 0)
			k = key_pool[$urandom_range(key_pool.size() - 1)]
				^ ({$urandom, $urandom} & 64'hFFFF_FF80_0000_0000);
		else if (pick < 25)
			k = 64'($urandom_range(255));
		else
			k = {$urandom, $urandom};
		if (k == '0)
			k = 64'd1;
		return k;
	endfunction

	function automatic logic [63:0] pool_key();
		if (key_pool.size() == 0)
			return fresh_key();
		return key_pool[$urandom_range(key_pool.size() - 1)];
	endfunction

	task automatic queue_random_ops(input int count, input int insert_pct,
			input int clear_per_mille);
		int r;
		logic [63:0] k;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if ($urandom_range(999) < clear_per_mille) begin
				push_cmd(OP_CLEAR, {$urandom, $urandom}, rand_word());
				key_pool.delete();
			end else if (r < insert_pct) begin
				k = fresh_key();
				key_pool.push_back(k);
				push_cmd(OP_UPSERT, k, rand_word());
			end else begin
				r = $urandom_range(99);
				if (r < 40)
					push_cmd(OP_LOOKUP, pool_key(), rand_word());
				else if (r < 70)
					push_cmd(OP_UPSERT, pool_key(), rand_word());
				else if (r < 85)
					push_cmd(OP_LOOKUP, fresh_key(), rand_word());
				else if (r < 92)
					push_cmd(r[0] ? OP_UPSERT : OP_LOOKUP, '0, rand_word());
				else
					push_cmd(OP_NOP, {$urandom, $urandom}, rand_word());
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || s_tvalid || expected_replies.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [63:0] wrap_key;
		logic [63:0] chain_key;
		empty_shadow();
		wrap_key = 64'd1;
		while (home_slot_of(wrap_key) != LAST_SLOT)
			wrap_key++;
		chain_key = 64'h0000_0012_3456_789a;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zero keys, the unused op, misses, hits, updates, collisions, wrap, clear.
		push_cmd(OP_LOOKUP, '0, '1);
		push_cmd(OP_UPSERT, '0, '1);
		push_cmd(OP_NOP, '0, '0);
		push_cmd(OP_NOP, '1, '1);
		push_cmd(OP_LOOKUP, 64'd1, '0);
		push_cmd(OP_UPSERT, 64'd1, '1);
		push_cmd(OP_UPSERT, '1, '0);
		push_cmd(OP_UPSERT, 64'd1, 64'h5555_5555_5555_5555);
		push_cmd(OP_LOOKUP, 64'd1, '0);
		push_cmd(OP_LOOKUP, '1, '0);
		push_cmd(OP_UPSERT, 64'h8000_0000_0000_0000, 64'd1);
		push_cmd(OP_UPSERT, chain_key, 64'hAAAA_AAAA_AAAA_AAAA);
		push_cmd(OP_UPSERT, chain_key ^ 64'h8000_0000_0000_0000, 64'd2);
		push_cmd(OP_UPSERT, chain_key ^ 64'h0000_0080_0000_0000, 64'd3);
		push_cmd(OP_LOOKUP, chain_key ^ 64'h0000_0080_0000_0000, '0);
		push_cmd(OP_LOOKUP, chain_key ^ 64'h4000_0000_0000_0000, '0);
		push_cmd(OP_UPSERT, wrap_key, 64'd10);
		push_cmd(OP_UPSERT, wrap_key ^ 64'h0000_0100_0000_0000, 64'd11);
		push_cmd(OP_UPSERT, wrap_key ^ 64'h0004_0000_0000_0000, 64'd12);
		push_cmd(OP_LOOKUP, wrap_key ^ 64'h0004_0000_0000_0000, '0);
		push_cmd(OP_CLEAR, '0, '0);
		push_cmd(OP_LOOKUP, 64'd1, '0);
		push_cmd(OP_CLEAR, '1, '1);
		push_cmd(OP_UPSERT, wrap_key, '1);

		// Random part, first phase: a fill-heavy mix that runs into the load limit.
		queue_random_ops(1000, 85, 0);
		wait_drained();

		send_idle_pct = 85;
		recv_idle_pct = 37;
		push_cmd(OP_CLEAR, '0, '0);
		key_pool.delete();
		queue_random_ops(500, 50, 4);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_cmd(OP_CLEAR, '0, '0);
		key_pool.delete();
		queue_random_ops(400, 60, 3);
		wait_drained();

		// Give any stray result time to show up.
		repeat (CAPACITY + 10) @(posedge clk);

		$display("Checked %0d results: %0d lookups, %0d upserts, %0d clears, %0d idle ops.",
			replies_checked, n_lookup, n_upsert, n_clear, n_nop);
		$display("Key hits %0d, load-limit refusals %0d, zero-key rejects %0d, mismatches %0d.",
			n_hit, n_full, n_zero, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
